// ----- rtl/adam_pkg.sv -----
// ----------------------------------------------------------------------------
// adam_pkg
// Shared widths, constants and stage types for the Adam update core.
// ----------------------------------------------------------------------------
package adam_pkg;

    localparam int DATA_W     = 32;
    localparam int COEF_W     = 24;
    localparam int FRAC_BITS  = 24;
    localparam int BIAS_FRAC  = 20;
    localparam int VHAT_W     = 44;
    localparam int ROOT_W     = 34;
    localparam int SQ_REM_W   = 36;
    localparam int SQ_STEPS   = 34;
    localparam int NUM_W      = 70;
    localparam int DEN_W      = 35;
    localparam int Q_W        = 41;
    localparam int DIV_STEPS  = 70;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;
    localparam logic [41:0] UPD_CAP = 42'h100_0000_0000;

    typedef enum logic [2:0] {
        REG_STEP_SIZE       = 3'd0,
        REG_BETA_FIRST      = 3'd1,
        REG_BETA_SECOND     = 3'd2,
        REG_EPSILON         = 3'd3,
        REG_INV_BIAS_FIRST  = 3'd4,
        REG_INV_BIAS_SECOND = 3'd5
    } cfg_reg_t;

    // values carried alongside the arithmetic
    typedef struct packed {
        logic signed [DATA_W-1:0] param;
        logic signed [DATA_W-1:0] mom1;
        logic        [DATA_W-1:0] mom2;
        logic                     neg;
    } side_t;

    typedef struct packed {
        logic [VHAT_W-1:0]   vhat;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [NUM_W-1:0]    num;
        side_t               side;
    } sq_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   quot;
        side_t            side;
    } dv_t;

    // one digit of the restoring square root; i is the bit-pair position
    function automatic sq_t sqrt_step(sq_t s, int i);
        sq_t         r;
        logic [1:0]  pair;
        logic [37:0] sh;
        logic [37:0] trial;
        r     = s;
        pair  = 2'b00;
        if (2 * i >= FRAC_BITS)
        begin
            pair = 2'(s.vhat >> (2 * i - FRAC_BITS));
        end
        sh    = {s.rem, pair};
        trial = 38'({s.root, 2'b01});
        if (sh >= trial)
        begin
            r.rem  = SQ_REM_W'(sh - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = SQ_REM_W'(sh);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one bit of the restoring division, quotient held at the cap
    function automatic dv_t div_step(dv_t s, int i);
        dv_t           r;
        logic [DEN_W:0] part;
        logic [Q_W:0]   qs;
        r    = s;
        part = {s.rem, s.num[i]};
        qs   = {s.quot, 1'b0};
        if (part >= {1'b0, s.den})
        begin
            part  = part - {1'b0, s.den};
            qs[0] = 1'b1;
        end
        if (qs >= UPD_CAP)
        begin
            qs = UPD_CAP;
        end
        r.rem  = part[DEN_W-1:0];
        r.quot = qs[Q_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/adam_optimizer_update_core.sv -----
// ----------------------------------------------------------------------------
// adam_optimizer_update_core
// Fused elementwise Adam update in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Input stream s_axis: one beat per element (param, gradient, moment 1,
// moment 2). Output stream m_axis: one beat per element (new param, new
// moment 1, new moment 2), in input order.
// Config channel cfg_*: register index and data, always ready; write only
// while no element is in flight.
// Throughput: one element per cycle while the skid register is empty. Stages:
// 6 arithmetic stages, 34 square-root digit stages, one denominator stage,
// 70 quotient-bit stages and the output register, in that order.
// Reset: all stage valid bits clear, registers return to their defaults
// (lr about 0.001, betas 0.9 / 0.999, epsilon one LSB).
// Stall: an output register and a skid register sit at the end; the pipe
// keeps taking beats while one result waits, and freezes as a whole once
// the skid register fills. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module adam_optimizer_update_core
    import adam_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // param_value, gradient, moment_one, moment_two
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_param, new_moment_one, new_moment_two
    output logic [95:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // configuration
    logic [COEF_W-1:0] step_size_reg;
    logic [COEF_W-1:0] beta_first_reg;
    logic [COEF_W-1:0] beta_second_reg;
    logic [COEF_W-1:0] epsilon_reg;
    logic [31:0]       inv_bias_first_reg;
    logic [31:0]       inv_bias_second_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg       <= 24'd16777;
            beta_first_reg      <= 24'd15099494;
            beta_second_reg     <= 24'd16760439;
            epsilon_reg         <= 24'd1;
            inv_bias_first_reg  <= 32'd10485760;
            inv_bias_second_reg <= 32'd1048576000;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STEP_SIZE:       step_size_reg       <= cfg_data[COEF_W-1:0];
                REG_BETA_FIRST:      beta_first_reg      <= cfg_data[COEF_W-1:0];
                REG_BETA_SECOND:     beta_second_reg     <= cfg_data[COEF_W-1:0];
                REG_EPSILON:         epsilon_reg         <= cfg_data[COEF_W-1:0];
                REG_INV_BIAS_FIRST:  inv_bias_first_reg  <= cfg_data;
                REG_INV_BIAS_SECOND: inv_bias_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable
    logic en;
    logic skid_vld_reg;
    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    // input fields
    logic signed [31:0] in_p;
    logic signed [31:0] in_g;
    logic signed [31:0] in_m;
    logic        [31:0] in_v;
    assign in_p = s_axis_tdata[31:0];
    assign in_g = s_axis_tdata[63:32];
    assign in_m = s_axis_tdata[95:64];
    assign in_v = s_axis_tdata[127:96];

    // stage 1: moment products and gradient square
    logic [24:0]        w1;
    logic signed [56:0] pm_next;
    logic signed [57:0] pg_next;
    logic [31:0]        gmag;
    logic [63:0]        gsq_next;
    side_t              s1_side_next;

    assign w1       = ONE_Q24 - {1'b0, beta_first_reg};
    assign pm_next  = $signed({1'b0, beta_first_reg}) * in_m;
    assign pg_next  = $signed({1'b0, w1}) * in_g;
    assign gmag     = in_g[31] ? 32'(-in_g) : in_g;
    assign gsq_next = 64'(gmag) * 64'(gmag);

    always_comb
    begin
        s1_side_next.param = in_p;
        s1_side_next.mom1  = in_m;
        s1_side_next.mom2  = in_v;
        s1_side_next.neg   = 1'b0;
    end

    logic               s1_vld_reg;
    logic signed [56:0] s1_pm_reg;
    logic signed [57:0] s1_pg_reg;
    logic [63:0]        s1_gsq_reg;
    side_t              s1_side_reg;

    // stage 2: round and saturate m1, round g^2
    logic signed [58:0] msum;
    logic signed [34:0] mshift;
    logic signed [31:0] m1_next;
    logic [63:0]        gsum;
    logic [38:0]        g2_next;
    side_t              s2_side_next;

    assign msum   = 59'(s1_pm_reg) + 59'(s1_pg_reg) + 59'sd8388608;
    assign mshift = msum[58:24];
    assign gsum   = s1_gsq_reg + 64'd8388608;
    assign g2_next = gsum[62:24];

    always_comb
    begin
        if ((mshift[34:31] == 4'b0000) || (mshift[34:31] == 4'b1111))
        begin
            m1_next = mshift[31:0];
        end
        else if (mshift[34])
        begin
            m1_next = 32'sh8000_0000;
        end
        else
        begin
            m1_next = 32'sh7fff_ffff;
        end
    end

    always_comb
    begin
        s2_side_next      = s1_side_reg;
        s2_side_next.mom1 = m1_next;
    end

    logic        s2_vld_reg;
    logic [38:0] s2_g2_reg;
    side_t       s2_side_reg;

    // stage 3: second moment partial products, bias product for m1
    logic [24:0] w2;
    logic [31:0] m1mag;
    logic [56:0] tlo_next;
    logic [31:0] thi_next;
    logic [55:0] tb_next;
    logic [63:0] mprod_next;
    side_t       s3_side_next;

    assign w2         = ONE_Q24 - {1'b0, beta_second_reg};
    assign tlo_next   = 57'(w2) * 57'(s2_g2_reg[31:0]);
    assign thi_next   = 32'(w2) * 32'(s2_g2_reg[38:32]);
    assign tb_next    = 56'(beta_second_reg) * 56'(s2_side_reg.mom2);
    assign m1mag      = s2_side_reg.mom1[31] ? 32'(-s2_side_reg.mom1) : s2_side_reg.mom1;
    assign mprod_next = 64'(m1mag) * 64'(inv_bias_first_reg);

    always_comb
    begin
        s3_side_next     = s2_side_reg;
        s3_side_next.neg = s2_side_reg.mom1[31];
    end

    logic        s3_vld_reg;
    logic [56:0] s3_tlo_reg;
    logic [31:0] s3_thi_reg;
    logic [55:0] s3_tb_reg;
    logic [63:0] s3_mprod_reg;
    side_t       s3_side_reg;

    // stage 4: v1 and m_hat
    logic [63:0] tsum;
    logic [31:0] v1_next;
    logic [64:0] msc;
    logic [44:0] mhat_next;
    side_t       s4_side_next;

    assign tsum      = 64'(s3_tlo_reg) + {s3_thi_reg, 32'd0} + 64'(s3_tb_reg) + 64'd8388608;
    assign v1_next   = (tsum[63:56] != 8'd0) ? 32'hffff_ffff : tsum[55:24];
    assign msc       = 65'(s3_mprod_reg) + 65'd524288;
    assign mhat_next = msc[64:20];

    always_comb
    begin
        s4_side_next      = s3_side_reg;
        s4_side_next.mom2 = v1_next;
    end

    logic        s4_vld_reg;
    logic [44:0] s4_mhat_reg;
    side_t       s4_side_reg;

    // stage 5: v_hat product, numerator partial products
    logic [63:0] vprod_next;
    logic [55:0] nlo_next;
    logic [36:0] nhi_next;

    assign vprod_next = 64'(s4_side_reg.mom2) * 64'(inv_bias_second_reg);
    assign nlo_next   = 56'(step_size_reg) * 56'(s4_mhat_reg[31:0]);
    assign nhi_next   = 37'(step_size_reg) * 37'(s4_mhat_reg[44:32]);

    logic        s5_vld_reg;
    logic [63:0] s5_vprod_reg;
    logic [55:0] s5_nlo_reg;
    logic [36:0] s5_nhi_reg;
    side_t       s5_side_reg;

    // stage 6: v_hat and numerator, entry of the root pipe
    logic [63:0] vsc;
    sq_t         sq_first;

    assign vsc = s5_vprod_reg + 64'd524288;

    always_comb
    begin
        sq_first.vhat = vsc[63:20];
        sq_first.rem  = '0;
        sq_first.root = '0;
        sq_first.num  = NUM_W'(69'(s5_nlo_reg) + {s5_nhi_reg, 32'd0});
        sq_first.side = s5_side_reg;
    end

    // square root digit stages
    logic sq_vld_reg [0:SQ_STEPS];
    sq_t  sq_reg     [0:SQ_STEPS];
    sq_t  sq_next    [1:SQ_STEPS];

    always_comb
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq_next[k+1] = sqrt_step(sq_reg[k], SQ_STEPS - 1 - k);
        end
    end

    // denominator, entry of the divider pipe
    logic [DEN_W-1:0] den_sum;
    dv_t              dv_first;

    assign den_sum = DEN_W'(sq_reg[SQ_STEPS].root) + DEN_W'(epsilon_reg);

    always_comb
    begin
        dv_first.num  = sq_reg[SQ_STEPS].num;
        dv_first.den  = (den_sum == '0) ? DEN_W'(1) : den_sum;
        dv_first.rem  = '0;
        dv_first.quot = '0;
        dv_first.side = sq_reg[SQ_STEPS].side;
    end

    // quotient bit stages
    logic dv_vld_reg [0:DIV_STEPS];
    dv_t  dv_reg     [0:DIV_STEPS];
    dv_t  dv_next    [1:DIV_STEPS];

    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dv_next[k+1] = div_step(dv_reg[k], DIV_STEPS - 1 - k);
        end
    end

    // final parameter update
    side_t              fin_side;
    logic signed [42:0] np_wide;
    logic signed [31:0] np_sat;
    logic [95:0]        result;

    assign fin_side = dv_reg[DIV_STEPS].side;
    assign np_wide  = fin_side.neg ? 43'(fin_side.param) + $signed({2'b00, dv_reg[DIV_STEPS].quot})
                                   : 43'(fin_side.param) - $signed({2'b00, dv_reg[DIV_STEPS].quot});

    always_comb
    begin
        if ((np_wide[42:31] == 12'h000) || (np_wide[42:31] == 12'hfff))
        begin
            np_sat = np_wide[31:0];
        end
        else if (np_wide[42])
        begin
            np_sat = 32'sh8000_0000;
        end
        else
        begin
            np_sat = 32'sh7fff_ffff;
        end
    end

    assign result = {fin_side.mom2, fin_side.mom1, np_sat};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_vld_reg    <= s_axis_tvalid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            sq_vld_reg[0] <= s5_vld_reg;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pm_reg         <= pm_next;
            s1_pg_reg         <= pg_next;
            s1_gsq_reg        <= gsq_next;
            s1_side_reg       <= s1_side_next;

            s2_g2_reg         <= g2_next;
            s2_side_reg       <= s2_side_next;

            s3_tlo_reg        <= tlo_next;
            s3_thi_reg        <= thi_next;
            s3_tb_reg         <= tb_next;
            s3_mprod_reg      <= mprod_next;
            s3_side_reg       <= s3_side_next;

            s4_mhat_reg       <= mhat_next;
            s4_side_reg       <= s4_side_next;

            s5_vprod_reg      <= vprod_next;
            s5_nlo_reg        <= nlo_next;
            s5_nhi_reg        <= nhi_next;
            s5_side_reg       <= s4_side_reg;

            sq_reg[0]         <= sq_first;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            dv_reg[0]         <= dv_first;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // output register and skid
    logic        out_vld_reg;
    logic [95:0] out_data_reg;
    logic [95:0] skid_data_reg;
    logic        take;
    logic        arrive;

    assign take   = out_vld_reg && m_axis_tready;
    assign arrive = en && dv_vld_reg[DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (arrive)
        begin
            if (out_vld_reg && !take)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (arrive)
        begin
            if (out_vld_reg && !take)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
